### rtl/nas_pkg.sv
package nas_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_SPACES    = 2'd1,
    KIND_FIELD_END = 2'd2,
    KIND_LINE_END  = 2'd3
  } kind_e;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_e;

  typedef struct packed {
    op_e   op;
    byte_t ch;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    byte_t       out_byte;
    logic [8:0]  space_count;
    logic [3:0]  field_index;
    logic [4:0]  field_total;
    logic        last;
  } out_t;

  // One accepted character or end marker, worth one or two results.
  typedef struct packed {
    logic two;
    out_t first;
    out_t second;
  } cmd_t;

  localparam byte_t CH_COMMA     = 8'h2C;
  localparam byte_t CH_QUOTE     = 8'h22;
  localparam byte_t CH_BACKSLASH = 8'h5C;
  localparam byte_t CH_SPACE     = 8'h20;
  localparam byte_t CH_LPAREN    = 8'h28;
  localparam byte_t CH_RPAREN    = 8'h29;
  localparam byte_t CH_LBRACE    = 8'h7B;
  localparam byte_t CH_RBRACE    = 8'h7D;
  localparam byte_t CH_LBRACKET  = 8'h5B;
  localparam byte_t CH_RBRACKET  = 8'h5D;

  localparam int unsigned DEPTH_W = 12;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 12'sd2047;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -12'sd2048;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

### rtl/nas_front.sv
module nas_front import nas_pkg::*; #(
  parameter int unsigned MAX_FIELDS      = 16,
  parameter int unsigned MAX_FIELD_BYTES = 511
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  input  logic queue_full_i,
  output logic push_o,
  output cmd_t cmd_o
);

  localparam int unsigned FW = $clog2(MAX_FIELDS + 1);
  localparam int unsigned LW = $clog2(MAX_FIELD_BYTES + 1);

  logic                        in_quote_q, in_quote_d;
  logic signed [DEPTH_W-1:0]   depth_q, depth_d;
  logic                        prev_bs_q, prev_bs_d;
  logic                        begun_q, begun_d;
  logic [LW-1:0]               len_q, len_d;
  logic [LW-1:0]               held_q, held_d;
  logic [FW-1:0]               done_q, done_d;

  function automatic out_t mk_result(input kind_e kind, input byte_t b,
                                     input logic [8:0] cnt, input logic [3:0] idx,
                                     input logic [4:0] tot, input logic lst);
    out_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.space_count = cnt;
    r.field_index = idx;
    r.field_total = tot;
    r.last        = lst;
    return r;
  endfunction

  assign in_ready_o = !queue_full_i;

  always_comb begin
    logic        quote;
    logic        is_open;
    logic        is_close;
    logic        sep;
    logic [LW:0] used;
    byte_t       c;
    logic [3:0]  idx;

    in_quote_d = in_quote_q;
    depth_d    = depth_q;
    prev_bs_d  = prev_bs_q;
    begun_d    = begun_q;
    len_d      = len_q;
    held_d     = held_q;
    done_d     = done_q;
    push_o     = 1'b0;
    cmd_o      = '0;

    c        = in_data_i.ch;
    idx      = 4'(done_q);
    quote    = (c == CH_QUOTE) && !prev_bs_q;
    is_open  = (c == CH_LPAREN) || (c == CH_LBRACE) || (c == CH_LBRACKET);
    is_close = (c == CH_RPAREN) || (c == CH_RBRACE) || (c == CH_RBRACKET);
    sep      = 1'b0;
    used     = {1'b0, len_q} + {1'b0, held_q};

    if (in_valid_i && in_ready_o) begin
      if (in_data_i.op == OP_END) begin
        push_o = 1'b1;
        if ((done_q < FW'(MAX_FIELDS)) && (len_q != '0)) begin
          cmd_o.two    = 1'b1;
          cmd_o.first  = mk_result(KIND_FIELD_END, '0, '0, idx, '0, 1'b0);
          cmd_o.second = mk_result(KIND_LINE_END, '0, '0, '0, 5'(done_q + 1'b1), 1'b1);
        end else begin
          cmd_o.second = mk_result(KIND_LINE_END, '0, '0, '0, 5'(done_q), 1'b1);
        end
        in_quote_d = 1'b0;
        depth_d    = '0;
        prev_bs_d  = 1'b0;
        begun_d    = 1'b0;
        len_d      = '0;
        held_d     = '0;
        done_d     = '0;
      end else if (done_q < FW'(MAX_FIELDS)) begin
        prev_bs_d = (c == CH_BACKSLASH);
        priority if (quote) begin
          in_quote_d = !in_quote_q;
        end else if (!in_quote_q && is_open) begin
          if (depth_q != DEPTH_MAX) depth_d = depth_q + 1'b1;
        end else if (!in_quote_q && is_close) begin
          if (depth_q != DEPTH_MIN) depth_d = depth_q - 1'b1;
        end else if (!in_quote_q && (depth_q == '0) && (c == CH_COMMA)) begin
          sep = 1'b1;
        end else begin
        end

        if (sep) begin
          push_o       = 1'b1;
          cmd_o.two    = (held_q != '0);
          cmd_o.first  = mk_result(KIND_SPACES, '0, 9'(held_q), idx, '0, 1'b0);
          cmd_o.second = mk_result(KIND_FIELD_END, '0, '0, idx, '0, 1'b1);
          done_d       = done_q + 1'b1;
          begun_d      = 1'b0;
          len_d        = '0;
          held_d       = '0;
        end else if (begun_q || (c != CH_SPACE)) begin
          begun_d = 1'b1;
          if (used < (LW + 1)'(MAX_FIELD_BYTES)) begin
            if (c == CH_SPACE) begin
              held_d = held_q + 1'b1;
            end else begin
              push_o       = 1'b1;
              cmd_o.two    = (held_q != '0);
              cmd_o.first  = mk_result(KIND_SPACES, '0, 9'(held_q), idx, '0, 1'b0);
              cmd_o.second = mk_result(KIND_BYTE, c, '0, idx, '0, 1'b1);
              len_d        = LW'(used + 1'b1);
              held_d       = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q <= 1'b0;
      depth_q    <= '0;
      prev_bs_q  <= 1'b0;
      begun_q    <= 1'b0;
      len_q      <= '0;
      held_q     <= '0;
      done_q     <= '0;
    end else begin
      in_quote_q <= in_quote_d;
      depth_q    <= depth_d;
      prev_bs_q  <= prev_bs_d;
      begun_q    <= begun_d;
      len_q      <= len_d;
      held_q     <= held_d;
      done_q     <= done_d;
    end
  end

endmodule

### rtl/nas_queue.sv
module nas_queue import nas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/nas_back.sv
module nas_back import nas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  cmd_t head_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic phase_q, phase_d;
  logic load;

  assign load        = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.two && !phase_q) begin
          out_d   = head_i.first;
          phase_d = 1'b1;
        end else begin
          out_d   = head_i.second;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

endmodule

### rtl/nested_argument_splitter_top.sv
// Splits a character stream into comma separated fields, honoring double quotes and
// bracket nesting. One character transaction is taken per cycle while the four entry
// command queue between the classifier and the output stage has room, and one result
// transaction leaves per cycle while out_ready_i is high; two results of one character
// leave the single output register one after the other, which sets the sustained rate.
// Each command is stored in the queue and then loaded into the output register.
module nested_argument_splitter_top import nas_pkg::*; #(
  parameter int unsigned MAX_FIELDS      = 16,
  parameter int unsigned MAX_FIELD_BYTES = 511
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic push;
  cmd_t cmd;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t head;

  nas_front #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .queue_full_i (full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  nas_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  nas_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue pushed while full");

  a_spaces_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KIND_SPACES)) |-> !out_data_o.last)
    else $error("space run closed a transaction");

  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KIND_LINE_END)) |-> out_data_o.last)
    else $error("end of line not marked last");

endmodule
